@@ rtl/pwkmc_pkg.sv @@
// shared types and constants for the power window key and motor controller
package pwkmc_pkg;

    localparam int THR_W   = 10;
    localparam int FILT_W  = 6;
    localparam int HOLD_W  = 8;
    localparam int TICK_W  = 16;
    localparam int DEB_W   = 8;
    localparam int CMD_W   = 3;
    localparam int MOT_W   = 3;
    localparam int DRV_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_THRESHOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_DOWN_TICKS = 3'd4;

    // register reset values
    localparam logic [THR_W-1:0]  RST_DOWN_THRESHOLD  = 10'd200;
    localparam logic [THR_W-1:0]  RST_UP_THRESHOLD    = 10'd600;
    localparam logic [FILT_W-1:0] RST_FILTER_COUNT    = 6'd5;
    localparam logic [HOLD_W-1:0] RST_HOLD_COUNT      = 8'd40;
    localparam logic [TICK_W-1:0] RST_AUTO_DOWN_TICKS = 16'd500;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE   = 3'b000;
    localparam logic [CMD_W-1:0] CMD_UP     = 3'b001;
    localparam logic [CMD_W-1:0] CMD_MANUAL = 3'b010;
    localparam logic [CMD_W-1:0] CMD_AUTO   = 3'b100;

    // motion flag codes
    localparam logic [MOT_W-1:0] MOT_UP   = 3'b001;
    localparam logic [MOT_W-1:0] MOT_DOWN = 3'b010;
    localparam logic [MOT_W-1:0] MOT_STOP = 3'b100;

    // drive output codes
    localparam logic [DRV_W-1:0] DRV_OFF  = 3'b000;
    localparam logic [DRV_W-1:0] DRV_UP   = 3'b001;
    localparam logic [DRV_W-1:0] DRV_DOWN = 3'b010;
    localparam logic [DRV_W-1:0] DRV_BUS  = 3'b100;

    typedef struct packed {
        logic [THR_W-1:0]  down_threshold;
        logic [THR_W-1:0]  up_threshold;
        logic [FILT_W-1:0] filter_count;
        logic [HOLD_W-1:0] hold_count;
        logic [TICK_W-1:0] auto_down_ticks;
    } cfg_t;

    typedef struct packed {
        logic [DEB_W-1:0] up_debounce;
        logic [DEB_W-1:0] down_debounce;
        logic [CMD_W-1:0] command;
    } key_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  previous_command;
        logic [TICK_W-1:0] auto_down_counter;
        logic [TICK_W-1:0] run_timer;
        logic [MOT_W-1:0]  motion_state;
        logic [DRV_W-1:0]  drive_outputs;
    } drv_state_t;

endpackage

@@ rtl/pwkmc_cfg_regs.sv @@
// configuration register file with reset defaults
module pwkmc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pwkmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwkmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pwkmc_pkg::cfg_t                     cfg
);

    pwkmc_pkg::cfg_t cfg_reg;
    pwkmc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                pwkmc_pkg::REG_DOWN_THRESHOLD: begin
                    cfg_next.down_threshold = cfg_data[pwkmc_pkg::THR_W-1:0];
                end
                pwkmc_pkg::REG_UP_THRESHOLD: begin
                    cfg_next.up_threshold = cfg_data[pwkmc_pkg::THR_W-1:0];
                end
                pwkmc_pkg::REG_FILTER_COUNT: begin
                    cfg_next.filter_count = cfg_data[pwkmc_pkg::FILT_W-1:0];
                end
                pwkmc_pkg::REG_HOLD_COUNT: begin
                    cfg_next.hold_count = cfg_data[pwkmc_pkg::HOLD_W-1:0];
                end
                pwkmc_pkg::REG_AUTO_DOWN_TICKS: begin
                    cfg_next.auto_down_ticks = cfg_data[pwkmc_pkg::TICK_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.down_threshold  <= pwkmc_pkg::RST_DOWN_THRESHOLD;
            cfg_reg.up_threshold    <= pwkmc_pkg::RST_UP_THRESHOLD;
            cfg_reg.filter_count    <= pwkmc_pkg::RST_FILTER_COUNT;
            cfg_reg.hold_count      <= pwkmc_pkg::RST_HOLD_COUNT;
            cfg_reg.auto_down_ticks <= pwkmc_pkg::RST_AUTO_DOWN_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pwkmc_key_scan.sv @@
// key ladder classification and debounce
module pwkmc_key_scan #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0]  key_sample,
    input  logic                    key_enable,
    input  pwkmc_pkg::cfg_t         cfg,
    input  pwkmc_pkg::key_state_t   key_state,
    output pwkmc_pkg::key_state_t   key_state_next
);

    localparam int CMP_W = (SAMPLE_BITS > pwkmc_pkg::THR_W) ? SAMPLE_BITS : pwkmc_pkg::THR_W;

    logic [CMP_W-1:0]                sample_ext;
    logic [CMP_W-1:0]                down_thr_ext;
    logic [CMP_W-1:0]                up_thr_ext;
    logic [pwkmc_pkg::DEB_W-1:0]     filter_ext;
    logic                            is_down;
    logic                            is_up;

    assign sample_ext   = CMP_W'(key_sample);
    assign down_thr_ext = CMP_W'(cfg.down_threshold);
    assign up_thr_ext   = CMP_W'(cfg.up_threshold);
    assign filter_ext   = pwkmc_pkg::DEB_W'(cfg.filter_count);
    assign is_down      = sample_ext < down_thr_ext;
    assign is_up        = sample_ext < up_thr_ext;

    always_comb begin
        key_state_next = key_state;
        if (key_enable) begin
            if (is_down) begin
                if (key_state.down_debounce < filter_ext) begin
                    key_state_next.down_debounce = key_state.down_debounce + 1'b1;
                end else if (key_state.down_debounce < cfg.hold_count) begin
                    key_state_next.down_debounce = key_state.down_debounce + 1'b1;
                    key_state_next.command       = pwkmc_pkg::CMD_AUTO;
                end else begin
                    key_state_next.command = pwkmc_pkg::CMD_MANUAL;
                end
            end else if (is_up) begin
                if (key_state.up_debounce < filter_ext) begin
                    key_state_next.up_debounce = key_state.up_debounce + 1'b1;
                end else if (key_state.up_debounce == filter_ext) begin
                    key_state_next.up_debounce = key_state.up_debounce + 1'b1;
                    key_state_next.command     = key_state.command | pwkmc_pkg::CMD_UP;
                end
            end else begin
                key_state_next.up_debounce   = '0;
                key_state_next.down_debounce = '0;
                if (key_state.command != pwkmc_pkg::CMD_AUTO) begin
                    key_state_next.command = pwkmc_pkg::CMD_NONE;
                end
            end
        end
    end

endmodule

@@ rtl/pwkmc_motor_drv.sv @@
// motor driver stage with auto-down timeout and run timer
module pwkmc_motor_drv (
    input  logic [pwkmc_pkg::CMD_W-1:0]   command_in,
    input  logic [pwkmc_pkg::TICK_W-1:0]  auto_down_ticks,
    input  pwkmc_pkg::drv_state_t         drv_state,
    output logic [pwkmc_pkg::CMD_W-1:0]   command_out,
    output pwkmc_pkg::drv_state_t         drv_state_next
);

    logic [pwkmc_pkg::TICK_W-1:0] adc_inc;
    logic [pwkmc_pkg::MOT_W-1:0]  mot_up;
    logic [pwkmc_pkg::MOT_W-1:0]  mot_down;

    assign adc_inc  = drv_state.auto_down_counter + 1'b1;
    assign mot_up   = (drv_state.motion_state | pwkmc_pkg::MOT_UP) & ~pwkmc_pkg::MOT_STOP;
    assign mot_down = (drv_state.motion_state | pwkmc_pkg::MOT_DOWN) & ~pwkmc_pkg::MOT_STOP;

    always_comb begin
        drv_state_next = drv_state;
        command_out    = command_in;

        case (command_in)
            pwkmc_pkg::CMD_MANUAL: begin
                drv_state_next.drive_outputs     = pwkmc_pkg::DRV_DOWN | pwkmc_pkg::DRV_BUS;
                drv_state_next.motion_state      = mot_down;
                drv_state_next.auto_down_counter = '0;
            end
            pwkmc_pkg::CMD_UP: begin
                drv_state_next.drive_outputs     = pwkmc_pkg::DRV_UP | pwkmc_pkg::DRV_BUS;
                drv_state_next.motion_state      = mot_up;
                drv_state_next.auto_down_counter = '0;
            end
            pwkmc_pkg::CMD_AUTO: begin
                if (adc_inc < auto_down_ticks) begin
                    drv_state_next.drive_outputs     = pwkmc_pkg::DRV_DOWN | pwkmc_pkg::DRV_BUS;
                    drv_state_next.motion_state      = mot_down;
                    drv_state_next.auto_down_counter = adc_inc;
                end else begin
                    // auto-down timed out
                    drv_state_next.drive_outputs     = pwkmc_pkg::DRV_OFF;
                    drv_state_next.motion_state      = pwkmc_pkg::MOT_STOP;
                    drv_state_next.auto_down_counter = '0;
                    command_out                      = pwkmc_pkg::CMD_NONE;
                end
            end
            default: begin
                // idle or combined codes stop the motor
                drv_state_next.drive_outputs     = pwkmc_pkg::DRV_OFF;
                drv_state_next.motion_state      = pwkmc_pkg::MOT_STOP;
                drv_state_next.auto_down_counter = '0;
            end
        endcase

        if (command_out != drv_state.previous_command) begin
            drv_state_next.previous_command = command_out;
            drv_state_next.run_timer        = auto_down_ticks;
        end

        if (drv_state_next.run_timer != '0) begin
            drv_state_next.run_timer = drv_state_next.run_timer - 1'b1;
            if (drv_state_next.run_timer == '0) begin
                drv_state_next.drive_outputs     = pwkmc_pkg::DRV_OFF;
                drv_state_next.motion_state      = pwkmc_pkg::MOT_STOP;
                drv_state_next.auto_down_counter = '0;
            end
        end
    end

endmodule

@@ rtl/power_window_key_and_motor_control.sv @@
// power window key scanner and motor controller, top level
// path: an accepted request moves from the input register to the result register on m_valid once that slot is free
// throughput: one request per cycle unless m_ready stalls; each tick is one pass of compares and counter updates
// while a result waits on m_ready the input register takes one more request, then s_ready drops
// reset (aresetn low, synchronous): registers to defaults, key and driver state cleared
// reset also empties the pipeline; no clearing pass is needed
module power_window_key_and_motor_control #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write port
    input  logic                                cfg_we,
    input  logic [pwkmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwkmc_pkg::CFG_DATA_W-1:0]    cfg_data,

    // key sample requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [SAMPLE_BITS-1:0]              s_key_sample,
    input  logic                                s_key_enable,

    // drive results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_up_drive,
    output logic                                m_down_drive,
    output logic                                m_bus_drive_flag,
    output logic [pwkmc_pkg::MOT_W-1:0]         m_motion_flags,
    output logic [pwkmc_pkg::CMD_W-1:0]         m_active_command
);

    pwkmc_pkg::cfg_t cfg;

    // input register stage
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [SAMPLE_BITS-1:0]    sample_reg;
    logic                      enable_reg;

    // persistent key and driver state
    pwkmc_pkg::key_state_t     key_state_reg;
    pwkmc_pkg::key_state_t     key_state_next;
    pwkmc_pkg::key_state_t     scan_state;
    pwkmc_pkg::drv_state_t     drv_state_reg;
    pwkmc_pkg::drv_state_t     drv_state_next;
    logic [pwkmc_pkg::CMD_W-1:0] drv_command;

    // result register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [pwkmc_pkg::DRV_W-1:0] out_drive_reg;
    logic [pwkmc_pkg::MOT_W-1:0] out_motion_reg;
    logic [pwkmc_pkg::CMD_W-1:0] out_command_reg;

    logic s_fire;
    logic step_fire;

    pwkmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result slot is free when empty or being drained this cycle
    assign step_fire = in_valid_reg && (!out_valid_reg || m_ready);
    // input slot takes a new request when empty or moving on to the result stage
    assign s_ready   = !in_valid_reg || step_fire;
    assign s_fire    = s_valid && s_ready;

    // key classification on the registered sample
    pwkmc_key_scan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .key_sample     (sample_reg),
        .key_enable     (enable_reg),
        .cfg            (cfg),
        .key_state      (key_state_reg),
        .key_state_next (scan_state)
    );

    // driver stage runs every tick on the scanned command
    pwkmc_motor_drv u_drv (
        .command_in      (scan_state.command),
        .auto_down_ticks (cfg.auto_down_ticks),
        .drv_state       (drv_state_reg),
        .command_out     (drv_command),
        .drv_state_next  (drv_state_next)
    );

    // driver may clear the command on auto-down timeout
    always_comb begin
        key_state_next         = scan_state;
        key_state_next.command = drv_command;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_state_reg <= '0;
            drv_state_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire) begin
                key_state_reg <= key_state_next;
                drv_state_reg <= drv_state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg <= s_key_sample;
            enable_reg <= s_key_enable;
        end
        if (step_fire) begin
            out_drive_reg   <= drv_state_next.drive_outputs;
            out_motion_reg  <= drv_state_next.motion_state;
            out_command_reg <= drv_command;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_up_drive       = out_drive_reg[0];
    assign m_down_drive     = out_drive_reg[1];
    assign m_bus_drive_flag = out_drive_reg[2];
    assign m_motion_flags   = out_motion_reg;
    assign m_active_command = out_command_reg;

`ifndef SYNTH
    // the relays are never driven both ways
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_up_drive && m_down_drive))
        else $error("up and down drive both on");

    // bus flag follows motor activity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bus_drive_flag == (m_up_drive || m_down_drive)))
        else $error("bus flag does not match drive");

    // stopped flag set exactly when the motor is off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_motion_flags[2] == !(m_up_drive || m_down_drive)))
        else $error("stop flag inconsistent with drive");

    // a held result is not overwritten while the input stage waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_drive_reg)
            && $stable(out_motion_reg) && $stable(out_command_reg)))
        else $error("held result changed");
`endif

endmodule

@@ verif/power_window_key_and_motor_control_tb.sv @@
// self-checking testbench for the power window key scanner and motor controller
module power_window_key_and_motor_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS     = 10;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int PHASES          = 8;
    localparam int PHASE_REQUESTS  = 72;

    // first register index past the implemented ones, writes there are dropped
    localparam logic [pwkmc_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
        pwkmc_pkg::REG_AUTO_DOWN_TICKS + 1'b1;

    // where a key reading lands relative to the two ladder thresholds
    typedef enum {KEY_DOWN, KEY_UP, KEY_RELEASE, KEY_NOISE} key_zone_t;

    typedef struct packed {
        logic                        up;
        logic                        down;
        logic                        bus;
        logic [pwkmc_pkg::MOT_W-1:0] motion;
        logic [pwkmc_pkg::CMD_W-1:0] cmd;
    } drive_result_t;

    // tracks key and motor state tick by tick and holds the drive results still owed
    class window_drive_board;
        pwkmc_pkg::cfg_t              regs;
        logic [pwkmc_pkg::DEB_W-1:0]  up_count;
        logic [pwkmc_pkg::DEB_W-1:0]  down_count;
        logic [pwkmc_pkg::CMD_W-1:0]  cmd;
        logic [pwkmc_pkg::CMD_W-1:0]  last_cmd;
        logic [pwkmc_pkg::TICK_W-1:0] auto_count;
        logic [pwkmc_pkg::TICK_W-1:0] run_left;
        logic [pwkmc_pkg::MOT_W-1:0]  motion;
        logic [pwkmc_pkg::DRV_W-1:0]  drive;
        drive_result_t                pending_drives[$];
        int                           errors;

        function new();
            regs.down_threshold  = pwkmc_pkg::RST_DOWN_THRESHOLD;
            regs.up_threshold    = pwkmc_pkg::RST_UP_THRESHOLD;
            regs.filter_count    = pwkmc_pkg::RST_FILTER_COUNT;
            regs.hold_count      = pwkmc_pkg::RST_HOLD_COUNT;
            regs.auto_down_ticks = pwkmc_pkg::RST_AUTO_DOWN_TICKS;
            up_count   = '0;
            down_count = '0;
            cmd        = pwkmc_pkg::CMD_NONE;
            last_cmd   = pwkmc_pkg::CMD_NONE;
            auto_count = '0;
            run_left   = '0;
            motion     = '0;
            drive      = pwkmc_pkg::DRV_OFF;
            errors     = 0;
        endfunction

        function void write_reg(logic [pwkmc_pkg::CFG_IDX_W-1:0] idx,
                                logic [pwkmc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pwkmc_pkg::REG_DOWN_THRESHOLD:
                    regs.down_threshold  = data[pwkmc_pkg::THR_W-1:0];
                pwkmc_pkg::REG_UP_THRESHOLD:
                    regs.up_threshold    = data[pwkmc_pkg::THR_W-1:0];
                pwkmc_pkg::REG_FILTER_COUNT:
                    regs.filter_count    = data[pwkmc_pkg::FILT_W-1:0];
                pwkmc_pkg::REG_HOLD_COUNT:
                    regs.hold_count      = data[pwkmc_pkg::HOLD_W-1:0];
                pwkmc_pkg::REG_AUTO_DOWN_TICKS:
                    regs.auto_down_ticks = data[pwkmc_pkg::TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void run_motor(logic [pwkmc_pkg::DRV_W-1:0] dir,
                                logic [pwkmc_pkg::MOT_W-1:0] seen);
            drive  = dir | pwkmc_pkg::DRV_BUS;
            motion = (motion | seen) & ~pwkmc_pkg::MOT_STOP;
        endfunction

        function void halt_motor();
            drive  = pwkmc_pkg::DRV_OFF;
            motion = pwkmc_pkg::MOT_STOP;
        endfunction

        function void note_tick(logic [SAMPLE_BITS-1:0] reading, logic enable);
            // key scan, frozen while keys are disabled
            if (enable) begin
                if (reading < regs.down_threshold) begin
                    if (down_count < regs.filter_count) begin
                        down_count = down_count + 1'b1;
                    end else if (down_count < regs.hold_count) begin
                        down_count = down_count + 1'b1;
                        cmd = pwkmc_pkg::CMD_AUTO;
                    end else begin
                        cmd = pwkmc_pkg::CMD_MANUAL;
                    end
                end else if (reading < regs.up_threshold) begin
                    if (up_count < regs.filter_count) begin
                        up_count = up_count + 1'b1;
                    end else if (up_count == regs.filter_count) begin
                        up_count = up_count + 1'b1;
                        cmd = cmd | pwkmc_pkg::CMD_UP;
                    end
                end else begin
                    up_count   = '0;
                    down_count = '0;
                    if (cmd != pwkmc_pkg::CMD_AUTO) cmd = pwkmc_pkg::CMD_NONE;
                end
            end

            // motor driver, combined codes fall to stop
            case (cmd)
                pwkmc_pkg::CMD_MANUAL: begin
                    run_motor(pwkmc_pkg::DRV_DOWN, pwkmc_pkg::MOT_DOWN);
                    auto_count = '0;
                end
                pwkmc_pkg::CMD_UP: begin
                    run_motor(pwkmc_pkg::DRV_UP, pwkmc_pkg::MOT_UP);
                    auto_count = '0;
                end
                pwkmc_pkg::CMD_AUTO: begin
                    auto_count = auto_count + 1'b1;
                    if (auto_count < regs.auto_down_ticks) begin
                        run_motor(pwkmc_pkg::DRV_DOWN, pwkmc_pkg::MOT_DOWN);
                    end else begin
                        auto_count = '0;
                        cmd = pwkmc_pkg::CMD_NONE;
                        halt_motor();
                    end
                end
                default: begin
                    halt_motor();
                    auto_count = '0;
                end
            endcase

            // run timer, reloaded on any command change
            if (cmd != last_cmd) begin
                last_cmd = cmd;
                run_left = regs.auto_down_ticks;
            end
            if (run_left != '0) begin
                run_left = run_left - 1'b1;
                if (run_left == '0) begin
                    halt_motor();
                    auto_count = '0;
                end
            end

            pending_drives.push_back(drive_result_t'{up: |(drive & pwkmc_pkg::DRV_UP),
                                                     down: |(drive & pwkmc_pkg::DRV_DOWN),
                                                     bus: |(drive & pwkmc_pkg::DRV_BUS),
                                                     motion: motion,
                                                     cmd: cmd});
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_drive(drive_result_t got);
            drive_result_t want;
            if (pending_drives.size() == 0) begin
                $error("drive result with no request outstanding");
                errors++;
                return;
            end
            want = pending_drives.pop_front();
            check_field("up_drive", want.up, got.up);
            check_field("down_drive", want.down, got.down);
            check_field("bus_drive_flag", want.bus, got.bus);
            check_field("motion_flags", want.motion, got.motion);
            check_field("active_command", want.cmd, got.cmd);
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic                              aclk         = 1'b0;
    logic                              aresetn      = 1'b0;
    logic                              cfg_we       = 1'b0;
    logic [pwkmc_pkg::CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [pwkmc_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic [SAMPLE_BITS-1:0]            s_key_sample = '0;
    logic                              s_key_enable = 1'b0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic                              m_up_drive;
    logic                              m_down_drive;
    logic                              m_bus_drive_flag;
    logic [pwkmc_pkg::MOT_W-1:0]       m_motion_flags;
    logic [pwkmc_pkg::CMD_W-1:0]       m_active_command;

    // idling knobs for the request and result sides
    bit sender_gaps      = 1'b0;
    bit sink_stalls      = 1'b0;
    bit hold_off_request = 1'b0;
    int cycle_count;

    window_drive_board board = new();

    always #2 aclk = ~aclk;

    power_window_key_and_motor_control #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_sample    (s_key_sample),
        .s_key_enable    (s_key_enable),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_up_drive      (m_up_drive),
        .m_down_drive    (m_down_drive),
        .m_bus_drive_flag(m_bus_drive_flag),
        .m_motion_flags  (m_motion_flags),
        .m_active_command(m_active_command)
    );

    // both handshakes are sampled on the edge with pre-edge values, so the order of
    // processes inside a time step does not matter
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_tick(s_key_sample, s_key_enable);
            if (m_valid && m_ready) begin
                board.check_drive(drive_result_t'{up: m_up_drive,
                                                  down: m_down_drive,
                                                  bus: m_bus_drive_flag,
                                                  motion: m_motion_flags,
                                                  cmd: m_active_command});
            end
        end
    end

    // offer one request and hold it until accepted; an optional gap comes first so
    // valid is only ever lowered in a step where it is not raised again
    task automatic send_tick(input logic [SAMPLE_BITS-1:0] reading, input logic enable);
        if (sender_gaps && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_key_sample <= reading;
        s_key_enable <= enable;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait until every owed drive result is back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending_drives.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // write all five registers, then one write to an unused index that must be dropped
    task automatic load_settings(input int dt, input int ut, input int filt, input int hold,
                                 input int ticks);
        logic [pwkmc_pkg::CFG_IDX_W-1:0]  idx [6];
        logic [pwkmc_pkg::CFG_DATA_W-1:0] val [6];
        idx = '{pwkmc_pkg::REG_DOWN_THRESHOLD, pwkmc_pkg::REG_UP_THRESHOLD,
                pwkmc_pkg::REG_FILTER_COUNT, pwkmc_pkg::REG_HOLD_COUNT,
                pwkmc_pkg::REG_AUTO_DOWN_TICKS,
                pwkmc_pkg::CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED,
                                                     (1 << pwkmc_pkg::CFG_IDX_W) - 1))};
        val = '{pwkmc_pkg::CFG_DATA_W'(dt), pwkmc_pkg::CFG_DATA_W'(ut),
                pwkmc_pkg::CFG_DATA_W'(filt), pwkmc_pkg::CFG_DATA_W'(hold),
                pwkmc_pkg::CFG_DATA_W'(ticks), pwkmc_pkg::CFG_DATA_W'($urandom)};
        foreach (idx[i]) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            board.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // a ladder reading inside the requested zone under the current thresholds;
    // a zone that is empty under these thresholds falls back to any reading
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(key_zone_t zone);
        int dt = board.regs.down_threshold;
        int ut = board.regs.up_threshold;
        int lo = (dt > ut) ? dt : ut;
        case (zone)
            KEY_DOWN:    if (dt > 0) return SAMPLE_BITS'($urandom_range(0, dt - 1));
            KEY_UP:      if (ut > dt) return SAMPLE_BITS'($urandom_range(dt, ut - 1));
            KEY_RELEASE: return SAMPLE_BITS'($urandom_range(lo, SAMPLE_MAX));
            default: ;
        endcase
        return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    endfunction

    // random key activity: mostly presses followed by a release stretch, with some
    // noise readings and disabled ticks mixed in to break the sequences
    task automatic run_phase(input int count);
        int        sent;
        int        len;
        int        pick;
        key_zone_t zone;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                zone = KEY_DOWN;
                // half the down presses are short enough to latch auto-down
                if ($urandom_range(0, 1) == 1)
                    len = board.regs.filter_count + $urandom_range(1, 3);
                else
                    len = $urandom_range(1, board.regs.hold_count + 4);
            end else if (pick < 7) begin
                zone = KEY_UP;
                len = $urandom_range(1, board.regs.filter_count + 4);
            end else if (pick < 9) begin
                zone = KEY_RELEASE;
                len = $urandom_range(1, 30);
            end else begin
                zone = KEY_NOISE;
                len = $urandom_range(1, 8);
            end
            // long holds only now and then, they eat requests
            if (len > 60 && $urandom_range(0, 7) != 0) len = 60;
            repeat (len) begin
                send_tick(pick_sample(($urandom_range(0, 15) == 0) ? KEY_NOISE : zone),
                          $urandom_range(0, 11) != 0);
                sent++;
            end
            // let the window run out after a press, long enough for short timeouts
            if (zone == KEY_DOWN || zone == KEY_UP) begin
                repeat ($urandom_range(1, 30)) begin
                    send_tick(pick_sample(KEY_RELEASE), $urandom_range(0, 11) != 0);
                    sent++;
                end
            end
        end
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        wait (aresetn);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // end the run if it hangs
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("power_window_key_and_motor_control_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int p;
        int dt;
        int ut;
        int filt;
        int hold;
        int ticks;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: reading extremes, both sides of each threshold, keys off
        send_tick(10'd0, 1'b1);
        send_tick(10'd0, 1'b0);
        send_tick(10'd1023, 1'b1);
        send_tick(10'd199, 1'b1);
        send_tick(10'd200, 1'b1);
        send_tick(10'd599, 1'b1);
        send_tick(10'd600, 1'b1);
        send_tick(10'd1023, 1'b0);
        settle();

        // no debounce, short hold: a single down tick latches auto-down
        load_settings(200, 600, 0, 2, 10);
        send_tick(10'd0, 1'b1);
        send_tick(10'd1023, 1'b1);
        send_tick(10'd1023, 1'b1);
        settle();

        // auto-down limit lowered below the running count: stops on the next tick
        load_settings(200, 600, 0, 2, 2);
        send_tick(10'd1023, 1'b1);

        // held down key goes manual, then up on top of manual is a combined stop
        send_tick(10'd0, 1'b1);
        send_tick(10'd0, 1'b1);
        send_tick(10'd0, 1'b1);
        send_tick(10'd300, 1'b1);
        send_tick(10'd1023, 1'b1);

        // auto-down plus up is a combined stop, release then clears it
        send_tick(10'd0, 1'b1);
        send_tick(10'd300, 1'b1);
        send_tick(10'd1023, 1'b1);

        // plain up, cut short by the run timer
        send_tick(10'd300, 1'b1);
        send_tick(10'd300, 1'b1);
        send_tick(10'd1023, 1'b1);
        settle();

        // zero auto-down length: stops at once and the run timer stays idle
        load_settings(200, 600, 0, 2, 0);
        send_tick(10'd0, 1'b1);
        send_tick(10'd1023, 1'b1);

        // random phases, each with fresh settings taken while the block is idle
        for (p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: load_settings(0, SAMPLE_MAX, 0, 0, 0);
                1: load_settings(SAMPLE_MAX, 0, 39, 255, 65535);
                default: begin
                    dt    = $urandom_range(50, 500);
                    ut    = $urandom_range(dt + 50, 1000);
                    filt  = $urandom_range(0, 6);
                    hold  = $urandom_range(0, filt + 12);
                    ticks = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
                    load_settings(dt, ut, filt, hold, ticks);
                end
            endcase

            // the last phase runs flat out on both sides
            sender_gaps = (p < PHASES - 1) && (p != 3) && ($urandom_range(0, 3) != 0);
            sink_stalls = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);

            if (p == 3) begin
                // result side holds off while requests keep coming, so the block backs up
                hold_off_request = 1'b1;
                run_phase(PHASE_REQUESTS);
            end else if (p == 5) begin
                // request side pauses until every result has drained
                run_phase(PHASE_REQUESTS / 2);
                settle();
                run_phase(PHASE_REQUESTS / 2);
            end else begin
                run_phase(PHASE_REQUESTS);
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        if (board.errors == 0 && board.pending_drives.size() == 0)
            $display("power_window_key_and_motor_control_tb: clean");
        else
            $display("power_window_key_and_motor_control_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pwkmc_pkg.sv
rtl/pwkmc_cfg_regs.sv
rtl/pwkmc_key_scan.sv
rtl/pwkmc_motor_drv.sv
rtl/power_window_key_and_motor_control.sv
verif/power_window_key_and_motor_control_tb.sv
